// ===== rtl/cnn_layer_buffer_planner_assert.svh =====
// assertion macros for the checker file
`ifndef CNN_LAYER_BUFFER_PLANNER_ASSERT_SVH
`define CNN_LAYER_BUFFER_PLANNER_ASSERT_SVH

// same-cycle implication, clocked and reset-qualified
`define CNNLBP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("cnnlbp check failed");

// next-cycle implication
`define CNNLBP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("cnnlbp check failed");

`endif

// ===== rtl/cnnlbp_pkg.sv =====
package cnnlbp_pkg;

	localparam int ALIGN_WORDS = 262144;
	localparam int MAX_LAYERS  = 64;
	localparam int ADDR_BITS   = 32;

	// extended width for sums that are checked against the address range
	localparam int WIDE_BITS = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 2;
	localparam int CNT_BITS  = 7;
	localparam int IDX_BITS  = 6;

	localparam int DIM_BITS   = 10;
	localparam int ODIM_BITS  = 11;
	localparam int ACT_BITS   = 30;
	localparam int WINC_BITS  = 25;
	localparam int VOL_BITS   = 31;

	localparam int IN_DATA_W  = 48;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 160;
	localparam int OUT_USER_W = 3;

	localparam int QUEUE_DEPTH = 2;

	// floor(n/3) == (n*2731) >> 13 for n below 2048
	localparam int RECIP3       = 2731;
	localparam int RECIP3_SHIFT = 13;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_GEOM = 2'd1,
		ST_OVF  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_CALC,
		FR_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		MS_AREA,
		MS_ACT,
		MS_OW,
		MS_OH,
		MS_CC,
		MS_WT,
		MS_OO,
		MS_VOL
	} mul_step_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ADD,
		BK_FIN
	} back_state_t;

	typedef struct packed {
		logic [ACT_BITS-1:0]  act_size;
		logic [WINC_BITS-1:0] wt_inc;
		logic [VOL_BITS-1:0]  out_vol;
		logic [ODIM_BITS-1:0] out_w;
		logic [ODIM_BITS-1:0] out_h;
		logic [DIM_BITS-1:0]  chan_out;
		logic                 geo_bad;
		logic                 is_conv;
		logic                 expand;
		logic                 advance;
		logic                 pool;
	} layer_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic [IDX_BITS-1:0]  layer_index;
		logic [31:0]          addr_input;
		logic [31:0]          addr_output;
		logic [31:0]          addr_weights;
		logic [ODIM_BITS-1:0] out_width;
		logic [ODIM_BITS-1:0] out_height;
		logic [31:0]          total_words;
	} result_t;

	function automatic logic [31:0] to_word(input logic [ADDR_BITS-1:0] a);
		logic [WIDE_BITS-1:0] t;
		t = WIDE_BITS'(a);
		return t[31:0];
	endfunction

endpackage

// ===== rtl/cnn_layer_buffer_planner.sv =====
// channel   | dir | tdata (low bit up)                                | tuser (low bit up)
// s_axis    | in  | in_width, in_height, chan_in, chan_out,            | is_conv, expand_flag,
//           |     | kernel_size, stride_sel, pad_on, advance_addr      | pool_mark
// m_axis    | out | layer_index, addr_input, addr_output,              | pool_out, status
//           |     | addr_weights, out_width, out_height, total_words   |
//
// the front takes one layer at a time and no new one while it works: one load, eight steps of its shared
// multiplier, one push into the two-entry job queue, which waits while the queue is full
// the back works one job at a time (pop, pointer bump and align, checks and state update)
// and stalls in its final check step only while the output register is still full
// s_tready falls while the front is busy or its job cannot enter a full queue
// reset clears the pointers, the layer count, the queue and the output valid
module cnn_layer_buffer_planner
	import cnnlbp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [9:0] in_width, [19:10] in_height, [29:20] chan_in, [39:30] chan_out,
	// [41:40] kernel_size, [43:42] stride_sel, [44] pad_on, [45] advance_addr
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [0] is_conv, [1] expand_flag, [2] pool_mark
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [5:0] layer_index, [37:6] addr_input, [69:38] addr_output,
	// [101:70] addr_weights, [112:102] out_width, [123:113] out_height,
	// [155:124] total_words
	output logic [OUT_DATA_W-1:0] m_tdata,
	// [0] pool_out, [2:1] status
	output logic [OUT_USER_W-1:0] m_tuser
);

	logic        push, pop, pool;
	layer_job_t  wr_job, rd_job;
	queue_stat_t q_stat;
	result_t     res;
	status_t     status;

	cnnlbp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata),
		.in_user  (s_tuser),
		.push     (push),
		.push_job (wr_job),
		.q_stat   (q_stat)
	);

	cnnlbp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.stat   (q_stat)
	);

	cnnlbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (rd_job),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.res        (res),
		.out_status (status),
		.pool_out   (pool)
	);

	assign m_tdata = {4'b0000, res.total_words, res.out_height, res.out_width,
		res.addr_weights, res.addr_output, res.addr_input, res.layer_index};
	assign m_tuser = {status, pool};

endmodule

// ===== rtl/cnnlbp_front.sv =====
module cnnlbp_front
	import cnnlbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [IN_DATA_W-1:0] in_data,
	input  logic [IN_USER_W-1:0] in_user,
	output logic                 push,
	output layer_job_t           push_job,
	input  queue_stat_t          q_stat
);

	front_state_t state_q, state_d;
	mul_step_t    step_q, step_d;

	logic [DIM_BITS-1:0]  w_q, h_q, cin_q, cout_q;
	logic [1:0]           k_q, s_q;
	logic                 conv_q, exp_q, adv_q, pool_q;
	logic [ODIM_BITS-1:0] nw_q, nh_q;
	logic                 geo_bad_q;

	logic [19:0]          area_q, cc_q;
	logic [ACT_BITS-1:0]  act_q;
	logic [ODIM_BITS-1:0] ow_q, oh_q;
	logic [WINC_BITS-1:0] wt_q;
	logic [21:0]          oo_q;
	logic [VOL_BITS-1:0]  vol_q;

	logic [11:0] num_w, num_h;
	logic [3:0]  kk;
	logic [21:0] mul_a;
	logic [11:0] mul_b;
	logic [33:0] mul_p;
	logic        accept;

	function automatic logic [ODIM_BITS-1:0] stride_div(input logic [ODIM_BITS-1:0] n,
			input logic [1:0] s, input logic [33:0] p);
		logic [ODIM_BITS-1:0] q;
		case (s)
			2'd2: q = n >> 1;
			2'd3: q = p[RECIP3_SHIFT +: ODIM_BITS];
			default: q = n;
		endcase
		return q;
	endfunction

	assign in_ready = (state_q == FR_IDLE);
	assign accept   = in_valid && in_ready;

	// padded dimension minus kernel, sign bit flags a kernel that does not fit
	assign num_w = 12'(in_data[9:0]) + {10'd0, in_data[44], 1'b0} - 12'(in_data[41:40]);
	assign num_h = 12'(in_data[19:10]) + {10'd0, in_data[44], 1'b0} - 12'(in_data[41:40]);

	assign kk = {2'b00, k_q} * {2'b00, k_q};

	// one shared multiplier, one product per step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (step_q)
			MS_AREA: begin
				mul_a = 22'(w_q);
				mul_b = 12'(h_q);
			end
			MS_ACT: begin
				mul_a = 22'(area_q);
				mul_b = 12'(cin_q);
			end
			MS_OW: begin
				mul_a = 22'(nw_q);
				mul_b = 12'(RECIP3);
			end
			MS_OH: begin
				mul_a = 22'(nh_q);
				mul_b = 12'(RECIP3);
			end
			MS_CC: begin
				mul_a = 22'(cout_q);
				mul_b = 12'(cin_q);
			end
			MS_WT: begin
				mul_a = 22'(cc_q);
				mul_b = 12'(kk);
			end
			MS_OO: begin
				mul_a = 22'(ow_q);
				mul_b = 12'(oh_q);
			end
			MS_VOL: begin
				mul_a = oo_q;
				mul_b = 12'(cout_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 34'(mul_a) * 34'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			step_q  <= MS_AREA;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		push    = 1'b0;
		unique case (state_q)
			FR_IDLE: begin
				if (in_valid) begin
					state_d = FR_CALC;
					step_d  = MS_AREA;
				end
			end
			FR_CALC: begin
				step_d = mul_step_t'(step_q + 3'd1);
				if (step_q == MS_VOL) begin
					state_d = FR_PUSH;
				end
			end
			FR_PUSH: begin
				if (!q_stat.full) begin
					push    = 1'b1;
					state_d = FR_IDLE;
				end
			end
			default: begin
				state_d = FR_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			w_q       <= in_data[9:0];
			h_q       <= in_data[19:10];
			cin_q     <= in_data[29:20];
			cout_q    <= in_data[39:30];
			k_q       <= in_data[41:40];
			s_q       <= in_data[43:42];
			adv_q     <= in_data[45];
			conv_q    <= in_user[0];
			exp_q     <= in_user[1];
			pool_q    <= in_user[2];
			nw_q      <= num_w[ODIM_BITS-1:0];
			nh_q      <= num_h[ODIM_BITS-1:0];
			geo_bad_q <= num_w[11] | num_h[11];
		end
		if (state_q == FR_CALC) begin
			unique case (step_q)
				MS_AREA: area_q <= mul_p[19:0];
				MS_ACT:  act_q  <= mul_p[ACT_BITS-1:0];
				MS_OW:   ow_q   <= stride_div(nw_q, s_q, mul_p) + 11'd1;
				MS_OH:   oh_q   <= stride_div(nh_q, s_q, mul_p) + 11'd1;
				MS_CC:   cc_q   <= mul_p[19:0];
				MS_WT:   wt_q   <= WINC_BITS'(mul_p[23:0]) + WINC_BITS'(cout_q);
				MS_OO:   oo_q   <= mul_p[21:0];
				MS_VOL:  vol_q  <= mul_p[VOL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		push_job.act_size = act_q;
		push_job.wt_inc   = wt_q;
		push_job.out_vol  = vol_q;
		push_job.out_w    = ow_q;
		push_job.out_h    = oh_q;
		push_job.chan_out = cout_q;
		push_job.geo_bad  = geo_bad_q;
		push_job.is_conv  = conv_q;
		push_job.expand   = exp_q;
		push_job.advance  = adv_q;
		push_job.pool     = pool_q;
	end

endmodule

// ===== rtl/cnnlbp_queue.sv =====
module cnnlbp_queue
	import cnnlbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  layer_job_t  wr_job,
	input  logic        pop,
	output layer_job_t  rd_job,
	output queue_stat_t stat
);

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

	layer_job_t          entry_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
		logic [PTR_BITS-1:0] r;
		if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_job     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// ===== rtl/cnnlbp_back.sv =====
module cnnlbp_back
	import cnnlbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  layer_job_t  job,
	input  queue_stat_t q_stat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     res,
	output status_t     out_status,
	output logic        pool_out
);

	localparam logic [WIDE_BITS-1:0] ALIGN_M1 = WIDE_BITS'(ALIGN_WORDS - 1);

	back_state_t state_q, state_d;
	layer_job_t  job_q;

	logic [ADDR_BITS-1:0] next_act_q, last_act_q, next_wt_q;
	logic [CNT_BITS-1:0]  count_q;
	logic [WIDE_BITS-1:0] new_next_q;

	logic    out_valid_q;
	result_t res_q;
	status_t status_q;
	logic    pool_q;

	logic [WIDE_BITS-1:0] next_w, rounded, a_out, total, new_wt;
	logic [ADDR_BITS-1:0] new_last;
	logic                 ovf, out_free, fin;
	status_t              st;

	assign out_free = !out_valid_q || out_ready;
	assign fin      = (state_q == BK_FIN) && out_free;

	assign next_w  = WIDE_BITS'(next_act_q);
	// bump past the input, then round up to the alignment boundary
	assign rounded = (next_w + WIDE_BITS'(job_q.act_size) + ALIGN_M1) & ~ALIGN_M1;

	always_comb begin
		a_out    = new_next_q + ((job_q.expand && !job_q.advance) ?
			WIDE_BITS'(job_q.chan_out) : '0);
		total    = new_next_q + WIDE_BITS'(job_q.out_vol);
		new_wt   = WIDE_BITS'(next_wt_q) + (job_q.is_conv ? WIDE_BITS'(job_q.wt_inc) : '0);
		new_last = job_q.advance ? next_act_q : last_act_q;
		ovf      = (new_next_q[WIDE_BITS-1:ADDR_BITS] != '0)
			|| (a_out[WIDE_BITS-1:ADDR_BITS] != '0)
			|| (total[WIDE_BITS-1:ADDR_BITS] != '0)
			|| (new_wt[WIDE_BITS-1:ADDR_BITS] != '0);
		if (count_q >= CNT_BITS'(MAX_LAYERS)) begin
			st = ST_FULL;
		end else if (job_q.geo_bad) begin
			st = ST_GEOM;
		end else if (ovf) begin
			st = ST_OVF;
		end else begin
			st = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = BK_ADD;
				end
			end
			BK_ADD: begin
				state_d = BK_FIN;
			end
			BK_FIN: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			next_act_q  <= '0;
			last_act_q  <= '0;
			next_wt_q   <= '0;
			count_q     <= '0;
		end else begin
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fin && (st == ST_OK)) begin
				next_act_q <= new_next_q[ADDR_BITS-1:0];
				last_act_q <= new_last;
				next_wt_q  <= new_wt[ADDR_BITS-1:0];
				count_q    <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
		if (state_q == BK_ADD) begin
			new_next_q <= job_q.advance ? rounded : next_w;
		end
		if (fin) begin
			status_q <= st;
			pool_q   <= job_q.pool;
			if (st == ST_OK) begin
				res_q.layer_index  <= count_q[IDX_BITS-1:0];
				res_q.addr_input   <= to_word(new_last);
				res_q.addr_output  <= to_word(a_out[ADDR_BITS-1:0]);
				res_q.addr_weights <= to_word(next_wt_q);
				res_q.out_width    <= job_q.out_w;
				res_q.out_height   <= job_q.out_h;
				res_q.total_words  <= to_word(total[ADDR_BITS-1:0]);
			end else begin
				res_q <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign res        = res_q;
	assign out_status = status_q;
	assign pool_out   = pool_q;

endmodule

// ===== rtl/cnnlbp_checker.sv =====
module cnnlbp_checker
	import cnnlbp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser
);

`include "cnn_layer_buffer_planner_assert.svh"

	// a stalled transfer keeps its payload
	`CNNLBP_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// a rejected layer carries no addresses or sizes
	`CNNLBP_ASSERT_IMP(a_err_zero, clk, arst_n, m_tvalid && (m_tuser[2:1] != ST_OK), m_tdata == '0)

	// an accepted layer always has at least one output pixel each way
	`CNNLBP_ASSERT_IMP(a_dims, clk, arst_n, m_tvalid && (m_tuser[2:1] == ST_OK), (m_tdata[112:102] != 11'd0) && (m_tdata[123:113] != 11'd0))

	// the running total never lies below the layer input
	`CNNLBP_ASSERT_IMP(a_total, clk, arst_n, m_tvalid && (m_tuser[2:1] == ST_OK), m_tdata[155:124] >= m_tdata[37:6])

endmodule

bind cnn_layer_buffer_planner cnnlbp_checker u_checker (.*);
